// ----- rtl/tbhr_pkg.sv -----
// Shared types and constants for the time-bucketed history ring.
// Used by the controller, the datapath and the top level. No dependencies.
package tbhr_pkg;

  // Request command codes; six and seven are unused and fail
  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_GET      = 3'd1;
  localparam logic [2:0] CMD_SET      = 3'd2;
  localparam logic [2:0] CMD_MAX_MIN  = 3'd3;
  localparam logic [2:0] CMD_SET_END  = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  localparam logic signed [31:0] SAMPLE_FLOOR = 32'sh8000_0000;
  localparam logic signed [31:0] SAMPLE_CEIL  = 32'sh7FFF_FFFF;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_STEP,
    DP_SAVE_OFF,
    DP_SAVE_OFF_MM,
    DP_MM_INIT,
    DP_SCAN_STEP,
    DP_CLR_INIT,
    DP_CLR_STEP,
    DP_FILL_INIT,
    DP_FILL_STEP,
    DP_ADD_WRITE,
    DP_JUMP_WRITE,
    DP_SET_WR
  } dp_op_t;

  // Which result goes to the output register
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_OK,
    RES_GET,
    RES_MM
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     out_load;
    res_sel_t res_sel;
    logic     end_fix;   // write request end time instead of advancing it
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic off_neg;
    logic off_big;
    logic off_in_range;
    logic scan_more;
    logic fill_zero;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/tbhr_if.sv -----
// Handshake channel interfaces for the history ring: request, result, config.
// Depends on nothing; widths follow the field list of the block.
interface tbhr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] time_req;
  logic [31:0] end_time_in;
  logic signed [31:0] data;
  modport source (output valid, cmd, time_req, end_time_in, data, input ready);
  modport sink   (input valid, cmd, time_req, end_time_in, data, output ready);
endinterface

interface tbhr_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic signed [31:0] value;
  logic signed [31:0] min_value;
  modport source (output valid, ok, value, min_value, input ready);
  modport sink   (input valid, ok, value, min_value, output ready);
endinterface

interface tbhr_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/tbhr_ctrl.sv -----
// Controller state machine of the history ring.
// Depends on tbhr_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
module tbhr_ctrl
  import tbhr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    dcmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV1, S_CLASS, S_DIV2, S_MMCHK, S_SCAN,
    S_FILL, S_SWEEP, S_JUMP, S_GET, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  res_sel_t   res_r, res_nxt;
  logic       jump_r, jump_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    jump_nxt  = jump_r;
    dcmd      = '{op: DP_NOP, out_load: 1'b0, res_sel: res_r,
                  end_fix: (cmd_r == CMD_SET_END)};
    unique case (state_r)
      S_CLR: begin
        dcmd.op = DP_CLR_STEP;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op  = DP_LOAD;
          cmd_nxt  = in_cmd;
          jump_nxt = 1'b0;
          case (in_cmd) inside
            CMD_ADD, CMD_GET, CMD_SET, CMD_MAX_MIN, CMD_SET_END: state_nxt = S_DIV1;
            CMD_CLEAR: state_nxt = S_SWEEP;
            default: begin
              res_nxt   = RES_FAIL;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV1: begin
        if (!stat.div_done) begin
          dcmd.op = DP_DIV_STEP;
        end else if (cmd_r == CMD_MAX_MIN) begin
          dcmd.op   = DP_SAVE_OFF_MM;
          state_nxt = S_DIV2;
        end else begin
          dcmd.op   = DP_SAVE_OFF;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        res_nxt   = RES_FAIL;
        state_nxt = S_DONE;
        case (cmd_r) inside
          CMD_ADD, CMD_SET_END: begin
            if (!stat.off_neg) begin
              if (stat.off_big) begin
                dcmd.op   = DP_CLR_INIT;
                jump_nxt  = 1'b1;
                state_nxt = S_SWEEP;
              end else begin
                dcmd.op   = DP_FILL_INIT;
                state_nxt = S_FILL;
              end
            end
          end
          CMD_GET: begin
            if (stat.off_in_range) begin
              res_nxt   = RES_GET;
              state_nxt = S_GET;
            end
          end
          CMD_SET: begin
            if (stat.off_in_range) begin
              dcmd.op = DP_SET_WR;
              res_nxt = RES_OK;
            end
          end
          default: ;
        endcase
      end
      S_DIV2: begin
        if (!stat.div_done) begin
          dcmd.op = DP_DIV_STEP;
        end else begin
          dcmd.op   = DP_MM_INIT;
          state_nxt = S_MMCHK;
        end
      end
      S_MMCHK: begin
        if (stat.scan_more) begin
          res_nxt   = RES_MM;
          state_nxt = S_SCAN;
        end else begin
          res_nxt   = RES_FAIL;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        dcmd.op = DP_SCAN_STEP;
        if (!stat.scan_more) state_nxt = S_DONE;
      end
      S_FILL: begin
        if (stat.fill_zero) begin
          dcmd.op   = DP_ADD_WRITE;
          res_nxt   = RES_OK;
          state_nxt = S_DONE;
        end else begin
          dcmd.op = DP_FILL_STEP;
        end
      end
      S_SWEEP: begin
        dcmd.op = DP_CLR_STEP;
        if (stat.clr_last) begin
          res_nxt   = RES_OK;
          state_nxt = jump_r ? S_JUMP : S_DONE;
        end
      end
      S_JUMP: begin
        dcmd.op   = DP_JUMP_WRITE;
        state_nxt = S_DONE;
      end
      S_GET: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          dcmd.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cmd_r   <= CMD_ADD;
      res_r   <= RES_FAIL;
      jump_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      res_r   <= res_nxt;
      jump_r  <= jump_nxt;
    end
  end

endmodule

// ----- rtl/tbhr_dp.sv -----
// Datapath of the history ring: sample memory, serial divider, ring pointers,
// scan extremes, interval register and result register. Depends on tbhr_pkg.
module tbhr_dp
  import tbhr_pkg::*;
#(
  parameter int DEPTH          = 64,
  parameter int BYTES_PER_SLOT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            dcmd,
  output dp_stat_t           stat,
  input  logic [2:0]         in_cmd,
  input  logic [31:0]        in_time_req,
  input  logic [31:0]        in_end_time_in,
  input  logic signed [31:0] in_data,
  input  logic               cfg_valid,
  input  logic [30:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_min_value
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = 8 * BYTES_PER_SLOT;
  localparam logic signed [32:0] DEP_S = 33'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Sample memory
  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rd_data_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [SW-1:0] wd;

  logic [30:0]   interval_r;
  logic [30:0]   eff;
  logic [31:0]   end_r, t_r, te_r;
  logic signed [31:0] d_r;
  logic [AW-1:0] wslot_r, clr_cnt_r, fill_cnt_r;

  // Divider
  logic [31:0]   rem_r, quo_r;
  logic          neg_r;
  logic [5:0]    cnt_r;
  logic [31:0]   rem_sh, rem_n, quo_n;
  logic          ge;
  logic signed [32:0] off_c, off_r;
  logic [31:0]   load_src, div_diff, div_mag;
  logic [31:0]   div_src;

  // Scan
  logic signed [32:0] scan_off_r, scan_end_r, s_clamp, e_clamp;
  logic               rv_r;
  logic signed [31:0] hi_r, lo_r, rd_val;
  logic signed [SW-1:0] rd_s;

  logic [AW-1:0] wslot_inc;

  function automatic logic [AW-1:0] slot_of(input logic signed [32:0] off,
                                            input logic [AW-1:0] ws);
    logic signed [32:0] base;
    logic [AW+1:0]      sum;
    begin
      base = off + DEP_S;
      sum  = {1'b0, base[AW:0]} + {2'b00, ws};
      if (sum >= (AW+2)'(DEPTH)) sum = sum - (AW+2)'(DEPTH);
      slot_of = sum[AW-1:0];
    end
  endfunction

  assign eff       = (interval_r == 31'd0) ? 31'd1 : interval_r;
  assign wslot_inc = (wslot_r == LAST_SLOT) ? '0 : wslot_r + AW'(1);

  // One restoring division step
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign ge     = rem_sh >= {1'b0, eff};
  assign rem_n  = ge ? rem_sh - {1'b0, eff} : rem_sh;
  assign quo_n  = {quo_r[30:0], ge};
  assign off_c  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // Divider operand: add time (set_end_time adds at end minus interval)
  assign load_src = (in_cmd == CMD_SET_END) ? in_end_time_in - {1'b0, eff} : in_time_req;
  assign div_src  = (dcmd.op == DP_LOAD) ? load_src : te_r;
  assign div_diff = div_src - end_r;
  assign div_mag  = div_diff[31] ? (~div_diff + 32'd1) : div_diff;

  assign s_clamp = (off_r < -DEP_S) ? -DEP_S : off_r;
  assign e_clamp = (off_c > 33'sd0) ? 33'sd0 : off_c;

  assign rd_s   = rd_data_r;
  assign rd_val = 32'(rd_s);

  // Status back to the controller
  assign stat.div_done     = cnt_r[5];
  assign stat.off_neg      = off_r[32];
  assign stat.off_big      = off_r >= DEP_S - 33'sd1;
  assign stat.off_in_range = off_r[32] && (off_r >= -DEP_S);
  assign stat.scan_more    = scan_off_r < scan_end_r;
  assign stat.fill_zero    = (fill_cnt_r == '0);
  assign stat.clr_last     = (clr_cnt_r == LAST_SLOT);
  assign stat.out_free     = !out_valid || out_ready;

  // Memory port addresses
  always_comb begin
    we = 1'b0;
    wa = wslot_r;
    wd = '0;
    ra = (dcmd.op == DP_SCAN_STEP) ? slot_of(scan_off_r, wslot_r) : slot_of(off_r, wslot_r);
    case (dcmd.op)
      DP_CLR_STEP: begin
        we = 1'b1;
        wa = clr_cnt_r;
      end
      DP_FILL_STEP: we = 1'b1;
      DP_ADD_WRITE: begin
        we = 1'b1;
        wd = d_r[SW-1:0];
      end
      DP_JUMP_WRITE: begin
        we = 1'b1;
        wa = LAST_SLOT;
        wd = d_r[SW-1:0];
      end
      DP_SET_WR: begin
        we = 1'b1;
        wa = slot_of(off_r, wslot_r);
        wd = d_r[SW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 31'd1;
      end_r      <= '0;
      wslot_r    <= '0;
      clr_cnt_r  <= '0;
      cnt_r      <= 6'd32;
      rv_r       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) interval_r <= cfg_data;
      rv_r <= 1'b0;
      case (dcmd.op)
        DP_LOAD: begin
          cnt_r <= '0;
          if (in_cmd == CMD_CLEAR) begin
            clr_cnt_r <= '0;
            wslot_r   <= '0;
            end_r     <= '0;
          end
        end
        DP_SAVE_OFF_MM: cnt_r <= '0;
        DP_DIV_STEP:    cnt_r <= cnt_r + 6'd1;
        DP_CLR_INIT:    clr_cnt_r <= '0;
        DP_CLR_STEP:    clr_cnt_r <= (clr_cnt_r == LAST_SLOT) ? '0 : clr_cnt_r + AW'(1);
        DP_FILL_STEP: begin
          wslot_r <= wslot_inc;
          end_r   <= end_r + {1'b0, eff};
        end
        DP_ADD_WRITE: begin
          wslot_r <= wslot_inc;
          end_r   <= dcmd.end_fix ? te_r : end_r + {1'b0, eff};
        end
        DP_JUMP_WRITE: begin
          wslot_r <= '0;
          end_r   <= dcmd.end_fix ? te_r : t_r + {1'b0, eff};
        end
        DP_SCAN_STEP: rv_r <= stat.scan_more;
        default: ;
      endcase
      if (dcmd.out_load)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (dcmd.op)
      DP_LOAD: begin
        t_r   <= load_src;
        te_r  <= in_end_time_in;
        d_r   <= (in_cmd == CMD_SET_END) ? 32'sd0 : in_data;
        rem_r <= '0;
        quo_r <= div_mag;
        neg_r <= div_diff[31];
      end
      DP_DIV_STEP: begin
        rem_r <= rem_n;
        quo_r <= quo_n;
      end
      DP_SAVE_OFF: off_r <= off_c;
      DP_SAVE_OFF_MM: begin
        off_r <= off_c;
        rem_r <= '0;
        quo_r <= div_mag;
        neg_r <= div_diff[31];
      end
      DP_MM_INIT: begin
        scan_off_r <= s_clamp;
        scan_end_r <= e_clamp;
        hi_r       <= SAMPLE_FLOOR;
        lo_r       <= SAMPLE_CEIL;
      end
      DP_SCAN_STEP: if (stat.scan_more) scan_off_r <= scan_off_r + 33'sd1;
      DP_FILL_INIT: fill_cnt_r <= off_r[AW-1:0];
      DP_FILL_STEP: fill_cnt_r <= fill_cnt_r - AW'(1);
      default: ;
    endcase
    // Extremes follow the registered read in the cycle after its address
    if (rv_r) begin
      if (rd_val > hi_r) hi_r <= rd_val;
      if (rd_val < lo_r) lo_r <= rd_val;
    end
    if (dcmd.out_load) begin
      out_ok        <= (dcmd.res_sel != RES_FAIL);
      out_value     <= '0;
      out_min_value <= '0;
      case (dcmd.res_sel)
        RES_GET: out_value <= rd_val;
        RES_MM: begin
          out_value     <= hi_r;
          out_min_value <= lo_r;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/time_bucketed_history_ring_top.sv -----
// Top level of the time-bucketed history ring.
// Depends on tbhr_pkg, the channel interfaces, tbhr_ctrl and tbhr_dp.

// A ring of DEPTH signed samples, one slot per interval_time time units, with
// commands add, get, set, max_min, set_end_time and clear. One request is
// handled at a time; its result sits in an output register, so a new request
// is taken while the previous result waits. Every timestamp goes through a
// one-bit-a-cycle divider, which sets most of the latency; max_min runs it
// twice. An add zeroes each slot that it skips, and a jump of DEPTH-1 slots
// or more runs a clearing sweep over all DEPTH slots instead; max_min scans
// every slot in the window, and clear sweeps the whole ring. After reset
// the memory is cleared before the first request is taken;
// configuration writes are accepted at any time.
module time_bucketed_history_ring_top
  import tbhr_pkg::*;
#(
  parameter int DEPTH          = 64,
  parameter int BYTES_PER_SLOT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  tbhr_in_if.sink    in_ch,
  tbhr_out_if.source out_ch,
  tbhr_cfg_if.sink   cfg_ch
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  tbhr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  tbhr_dp #(
    .DEPTH          (DEPTH),
    .BYTES_PER_SLOT (BYTES_PER_SLOT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dcmd           (dcmd),
    .stat           (stat),
    .in_cmd         (in_ch.cmd),
    .in_time_req    (in_ch.time_req),
    .in_end_time_in (in_ch.end_time_in),
    .in_data        (in_ch.data),
    .cfg_valid      (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ok         (out_ch.ok),
    .out_value      (out_ch.value),
    .out_min_value  (out_ch.min_value)
  );

endmodule
